/* sv/overwriting_event_ring_queue_unit_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the overwriting event ring queue
// Clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef OVERWRITING_EVENT_RING_QUEUE_UNIT_DEFINES_SVH
`define OVERWRITING_EVENT_RING_QUEUE_UNIT_DEFINES_SVH

// cond holds at every edge
`define OERQ_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// pre at one edge implies post at the next
`define OERQ_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

/* sv/oerq_pkg.sv */
// ---------------------------------------------------------------------------
// oerq_pkg
// Shared types and constants of the overwriting event ring queue.
// ---------------------------------------------------------------------------
package oerq_pkg;

	localparam int QUEUE_DEPTH_DEF = 32;
	localparam int EVENT_WIDTH_DEF = 32;

	localparam int OPER_W    = 2;
	localparam int EVT_W     = 32;
	localparam int CNT_OUT_W = 6;

	typedef enum logic [OPER_W-1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_PEEK  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef struct packed {
		logic                 event_valid;
		logic                 overflow_now;
		logic                 queue_empty;
		logic [CNT_OUT_W-1:0] entry_count;
	} res_t;

endpackage

/* sv/oerq_ram.sv */
// ---------------------------------------------------------------------------
// oerq_ram
// Generic one-write, one-read RAM with registered read data.
// ---------------------------------------------------------------------------
module oerq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* sv/oerq_ctrl.sv */
// ---------------------------------------------------------------------------
// oerq_ctrl
// Head/tail/count bookkeeping, RAM request and the registered result flags.
// ---------------------------------------------------------------------------
`include "overwriting_event_ring_queue_unit_defines.svh"

module oerq_ctrl #(
	parameter int QUEUE_DEPTH = oerq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic                           take,
	input  oerq_pkg::op_t                  operation,
	output logic                           ram_we,
	output logic [$clog2(QUEUE_DEPTH)-1:0] ram_waddr,
	output logic                           ram_re,
	output logic [$clog2(QUEUE_DEPTH)-1:0] ram_raddr,
	output logic                           valid_s1,
	output oerq_pkg::res_t                 res_s1
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	logic [PTR_W-1:0] head_q, tail_q, head_d, tail_d;
	logic [PTR_W-1:0] head_inc, tail_inc, newest;
	logic [CNT_W-1:0] count_q, count_d;
	logic             full, empty, rd_hit, ovf;

	assign full     = (count_q == CNT_FULL);
	assign empty    = (count_q == '0);
	assign head_inc = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
	assign tail_inc = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
	assign newest   = (tail_q == '0) ? PTR_LAST : tail_q - 1'b1;

	always_comb begin
		head_d    = head_q;
		tail_d    = tail_q;
		count_d   = count_q;
		rd_hit    = 1'b0;
		ovf       = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = tail_q;
		ram_raddr = head_q;
		case (operation)
			oerq_pkg::OP_PUSH: begin
				ram_we = accept;
				tail_d = tail_inc;
				if (full) begin
					head_d = head_inc;
					ovf    = 1'b1;
				end else begin
					count_d = count_q + 1'b1;
				end
			end
			oerq_pkg::OP_POP: begin
				if (!empty) begin
					ram_re  = accept;
					rd_hit  = 1'b1;
					head_d  = head_inc;
					count_d = count_q - 1'b1;
				end
			end
			oerq_pkg::OP_PEEK: begin
				ram_raddr = newest;
				if (!empty) begin
					ram_re = accept;
					rd_hit = 1'b1;
				end
			end
			default: begin
				head_d  = '0;
				tail_d  = '0;
				count_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				head_q   <= head_d;
				tail_q   <= tail_d;
				count_q  <= count_d;
				valid_s1 <= 1'b1;
			end else if (take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1.event_valid  <= rd_hit;
			res_s1.overflow_now <= ovf;
			res_s1.queue_empty  <= (count_d == '0);
			res_s1.entry_count  <= oerq_pkg::CNT_OUT_W'(count_d);
		end
	end

	`OERQ_ASSERT_ALWAYS(a_count_range, count_q <= CNT_FULL, "count above depth")
	`OERQ_ASSERT_ALWAYS(a_ptr_meet, (count_q != '0 && count_q != CNT_FULL) || head_q == tail_q,
		"empty or full queue with head and tail apart")
	`OERQ_ASSERT_ALWAYS(a_res_count, !valid_s1 || res_s1.entry_count == oerq_pkg::CNT_OUT_W'(count_q),
		"held result count differs from queue count")
	`OERQ_ASSERT_NEXT(a_clear, accept && operation == oerq_pkg::OP_CLEAR,
		count_q == '0 && head_q == '0 && tail_q == '0, "clear left state behind")

endmodule

/* sv/overwriting_event_ring_queue_unit.sv */
// ---------------------------------------------------------------------------
// overwriting_event_ring_queue_unit
// Circular event queue that overwrites the oldest entry when full.
// ---------------------------------------------------------------------------
// Input channel s_*: one operation per transfer, s_tuser carries the
// operation (push, pop oldest, peek newest, clear), s_tdata the event word.
// Output channel m_*: exactly one result per accepted operation, in order.
// m_tuser flags a real event in the low tdata bits; the rest of m_tdata gives
// the overflow pulse, the empty flag and the entry count after the operation.
// Latency: the result is offered on the cycle after the input transfer.
// Throughput: one operation per cycle while m_tready is high; pointers and count
// are registered on each accepted operation and the event RAM is read or written at most once per operation.
// The result register holds while m_tready is low; s_tready then follows
// m_tready, so input is accepted whenever the result slot frees up.
// Reset clears head, tail, count and the result slot; the event RAM is not
// cleared and needs no sweep, only written entries are ever read back.
// ---------------------------------------------------------------------------
module overwriting_event_ring_queue_unit #(
	parameter int QUEUE_DEPTH = oerq_pkg::QUEUE_DEPTH_DEF,
	parameter int EVENT_WIDTH = oerq_pkg::EVENT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // event_in[31:0]
	input  logic [1:0]  s_tuser,  // operation[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // event_out[31:0], overflow_now, queue_empty, entry_count[5:0]
	output logic        m_tuser   // event_valid
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	logic                   accept, take, valid_s1;
	logic                   ram_we, ram_re;
	logic [PTR_W-1:0]       ram_waddr, ram_raddr;
	logic [EVENT_WIDTH-1:0] ram_wdata, ram_rdata;
	logic [oerq_pkg::EVT_W-1:0] event_out;
	oerq_pkg::res_t         res_s1;

	assign s_tready  = !valid_s1 || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign take      = valid_s1 && m_tready;
	assign ram_wdata = EVENT_WIDTH'(s_tdata);

	oerq_ctrl #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.take      (take),
		.operation (oerq_pkg::op_t'(s_tuser)),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.valid_s1  (valid_s1),
		.res_s1    (res_s1)
	);

	oerq_ram #(
		.WIDTH (EVENT_WIDTH),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign event_out = res_s1.event_valid ? oerq_pkg::EVT_W'(ram_rdata) : '0;
	assign m_tvalid  = valid_s1;
	assign m_tdata   = {res_s1.entry_count, res_s1.queue_empty, res_s1.overflow_now, event_out};
	assign m_tuser   = res_s1.event_valid;

endmodule
